// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Define ASSERT_OFF to compile all checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/rmeg_pkg.sv
`default_nettype none

package rmeg_pkg;

    // Sizes
    localparam int VERTEX_BITS   = 16;
    localparam int FRACTION_BITS = 24;
    localparam int COUNT_BITS    = 32;
    localparam int SCALE_W       = 5;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_VERTICES  = 1 << VERTEX_BITS;

    // Operation codes of an input request
    localparam logic [OP_W-1:0] OP_DRAW = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TH_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TH_AB  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TH_ABC = 2'd3;

    // Result kinds
    localparam logic RES_EDGE  = 1'b0;
    localparam logic RES_COUNT = 1'b1;

    // Quadrant probabilities in percent: a, then b and c
    localparam int PROB_A_PCT = 57;
    localparam int PROB_B_PCT = 19;
    localparam int PROB_C_PCT = 19;

    // Reset values of the configuration registers
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(VERTEX_BITS);
    localparam logic [FRACTION_BITS-1:0] TH_A_RST =
        FRACTION_BITS'((64'(PROB_A_PCT) << FRACTION_BITS) / 64'd100);
    localparam logic [FRACTION_BITS-1:0] TH_AB_RST =
        FRACTION_BITS'((64'(PROB_A_PCT + PROB_B_PCT) << FRACTION_BITS) / 64'd100);
    localparam logic [FRACTION_BITS-1:0] TH_ABC_RST =
        FRACTION_BITS'((64'(PROB_A_PCT + PROB_B_PCT + PROB_C_PCT) << FRACTION_BITS)
                       / 64'd100);

    // Command passed from the front to the back
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_READ = 2'd1,
        CMD_EDGE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [VERTEX_BITS-1:0] arg_a;   // index, or source id
        logic [VERTEX_BITS-1:0] arg_b;   // mapped id, or target id
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/core/rmeg_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
// that holds while no read is issued.
module rmeg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rmeg_front.sv
`default_nettype none

`include "assert_macros.svh"

module rmeg_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rmeg_pkg::OP_W-1:0]           s_operation,
    input  wire logic [rmeg_pkg::FRACTION_BITS-1:0]  s_draw_fraction,
    input  wire logic [rmeg_pkg::VERTEX_BITS-1:0]    s_vertex_index,
    input  wire logic [rmeg_pkg::VERTEX_BITS-1:0]    s_mapped_id,
    // configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rmeg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmeg_pkg::FRACTION_BITS-1:0]  cfg_wdata,
    // to queue
    input  wire rmeg_pkg::queue_status_t             q_status,
    input  wire logic                                back_clearing,
    output rmeg_pkg::push_t                          q_push
);

    import rmeg_pkg::*;

    logic [SCALE_W-1:0]       scale_reg;
    logic [FRACTION_BITS-1:0] th_a_reg, th_ab_reg, th_abc_reg;
    logic [VERTEX_BITS-1:0]   src_reg, src_next;
    logic [VERTEX_BITS-1:0]   tgt_reg, tgt_next;
    logic [SCALE_W-1:0]       draws_reg, draws_next;

    logic [SCALE_W-1:0]       scale_eff;
    logic [SCALE_W-1:0]       draw_count;
    logic [VERTEX_BITS-1:0]   src_shift, tgt_shift;
    logic                     src_bit, tgt_bit;
    logic                     accept;

    // Ready while the count memory is not being cleared and the queue has room
    assign s_ready   = !back_clearing && !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_RST;
            th_a_reg   <= TH_A_RST;
            th_ab_reg  <= TH_AB_RST;
            th_abc_reg <= TH_ABC_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                CFG_TH_A:   th_a_reg   <= cfg_wdata;
                CFG_TH_AB:  th_ab_reg  <= cfg_wdata;
                CFG_TH_ABC: th_abc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective scale, clamped to 1..VERTEX_BITS
    always_comb begin
        if (scale_reg == '0) begin
            scale_eff = SCALE_W'(1);
        end else if (scale_reg > SCALE_W'(VERTEX_BITS)) begin
            scale_eff = SCALE_W'(VERTEX_BITS);
        end else begin
            scale_eff = scale_reg;
        end
    end

    // Quadrant choice: strict compares tried in order
    always_comb begin
        if (s_draw_fraction < th_a_reg) begin
            src_bit = 1'b0;
            tgt_bit = 1'b0;
        end else if (s_draw_fraction < th_ab_reg) begin
            src_bit = 1'b0;
            tgt_bit = 1'b1;
        end else if (s_draw_fraction < th_abc_reg) begin
            src_bit = 1'b1;
            tgt_bit = 1'b0;
        end else begin
            src_bit = 1'b1;
            tgt_bit = 1'b1;
        end
    end

    assign src_shift  = (src_reg << 1) | VERTEX_BITS'(src_bit);
    assign tgt_shift  = (tgt_reg << 1) | VERTEX_BITS'(tgt_bit);
    assign draw_count = draws_reg + SCALE_W'(1);

    // Classify the request and build the command for the back
    always_comb begin
        src_next         = src_reg;
        tgt_next         = tgt_reg;
        draws_next       = draws_reg;
        q_push.valid     = 1'b0;
        q_push.cmd.kind  = CMD_EDGE;
        q_push.cmd.arg_a = s_vertex_index;
        q_push.cmd.arg_b = s_mapped_id;
        if (accept) begin
            case (s_operation)
                OP_DRAW: begin
                    if (draw_count >= scale_eff) begin
                        q_push.valid     = 1'b1;
                        q_push.cmd.kind  = CMD_EDGE;
                        q_push.cmd.arg_a = src_shift;
                        q_push.cmd.arg_b = tgt_shift;
                        src_next         = '0;
                        tgt_next         = '0;
                        draws_next       = '0;
                    end else begin
                        src_next   = src_shift;
                        tgt_next   = tgt_shift;
                        draws_next = draw_count;
                    end
                end
                OP_LOAD: begin
                    q_push.valid    = 1'b1;
                    q_push.cmd.kind = CMD_LOAD;
                end
                OP_READ: begin
                    q_push.valid     = 1'b1;
                    q_push.cmd.kind  = CMD_READ;
                    q_push.cmd.arg_b = '0;
                end
                default: ;
            endcase
        end
    end

    // Partial edge state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg   <= '0;
            tgt_reg   <= '0;
            draws_reg <= '0;
        end else begin
            src_reg   <= src_next;
            tgt_reg   <= tgt_next;
            draws_reg <= draws_next;
        end
    end

    // A partial edge never holds the largest scale (VERTEX_BITS) of draws
    `ASSERT_IMPLIES(a_draws_bound, aclk, aresetn, 1'b1, draws_reg < SCALE_W'(VERTEX_BITS))

endmodule

`default_nettype wire

// File: rtl/core/rmeg_queue.sv
`default_nettype none

`include "assert_macros.svh"

// Short command queue between the front and the back.
module rmeg_queue (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire rmeg_pkg::push_t          q_push,
    input  wire logic                     q_pop,
    output rmeg_pkg::cmd_t                q_head,
    output rmeg_pkg::queue_status_t       q_status
);

    import rmeg_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_head         = entry_reg[rptr_reg];

    // Occupancy
    always_comb begin
        count_next = count_reg;
        if (q_push.valid && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!q_push.valid && q_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (q_push.valid) begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            entry_reg[wptr_reg] <= q_push.cmd;
        end
    end

    `ASSERT_IMPLIES(a_q_no_overflow, aclk, aresetn, q_push.valid, !q_status.full)
    `ASSERT_IMPLIES(a_q_no_underflow, aclk, aresetn, q_pop, !q_status.empty)

endmodule

`default_nettype wire

// File: rtl/core/rmeg_back.sv
`default_nettype none

`include "assert_macros.svh"

// Executes queued commands against the permutation and count memories and
// holds the result register.
module rmeg_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire rmeg_pkg::cmd_t                     q_head,
    input  wire rmeg_pkg::queue_status_t            q_status,
    output logic                                    q_pop,
    output logic                                    back_clearing,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_result_kind,
    output logic [rmeg_pkg::VERTEX_BITS-1:0]        m_source_vertex,
    output logic [rmeg_pkg::VERTEX_BITS-1:0]        m_target_vertex,
    output logic [rmeg_pkg::COUNT_BITS-1:0]         m_vertex_count
);

    import rmeg_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_RD_WAIT = 8'b0000_0100,
        S_E_PT    = 8'b0000_1000,
        S_E_CS    = 8'b0001_0000,
        S_E_WS    = 8'b0010_0000,
        S_E_CT    = 8'b0100_0000,
        S_E_WT    = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VERTEX_BITS-1:0] clr_addr_reg, clr_addr_next;

    // edge working registers
    logic [VERTEX_BITS-1:0] tgt_id_reg, tgt_id_next;
    logic [VERTEX_BITS-1:0] src_map_reg, src_map_next;
    logic [VERTEX_BITS-1:0] tgt_map_reg, tgt_map_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [VERTEX_BITS-1:0] out_src_reg, out_src_next;
    logic [VERTEX_BITS-1:0] out_tgt_reg, out_tgt_next;
    logic [COUNT_BITS-1:0]  out_cnt_reg, out_cnt_next;
    logic                   out_free;

    // memory ports
    logic                   perm_we, perm_re;
    logic [VERTEX_BITS-1:0] perm_waddr, perm_raddr, perm_wdata, perm_rdata;
    logic                   cnt_we, cnt_re;
    logic [VERTEX_BITS-1:0] cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rdata, cnt_inc;

    rmeg_ram #(
        .DATA_W (VERTEX_BITS),
        .DEPTH  (NUM_VERTICES)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rmeg_ram #(
        .DATA_W (COUNT_BITS),
        .DEPTH  (NUM_VERTICES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // saturating increment of the count just read
    assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);

    assign out_free      = !out_valid_reg || m_ready;
    assign back_clearing = (state_reg == S_CLEAR);

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_source_vertex = out_src_reg;
    assign m_target_vertex = out_tgt_reg;
    assign m_vertex_count  = out_cnt_reg;

    // Command sequencer
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        tgt_id_next    = tgt_id_reg;
        src_map_next   = src_map_reg;
        tgt_map_next   = tgt_map_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_src_next   = out_src_reg;
        out_tgt_next   = out_tgt_reg;
        out_cnt_next   = out_cnt_reg;
        q_pop          = 1'b0;
        perm_we        = 1'b0;
        perm_waddr     = q_head.arg_a;
        perm_wdata     = q_head.arg_b;
        perm_re        = 1'b0;
        perm_raddr     = q_head.arg_a;
        cnt_we         = 1'b0;
        cnt_waddr      = src_map_reg;
        cnt_wdata      = cnt_inc;
        cnt_re         = 1'b0;
        cnt_raddr      = q_head.arg_a;

        case (state_reg)
            // zero the counts, one entry a cycle
            S_CLEAR: begin
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                cnt_wdata     = '0;
                clr_addr_next = clr_addr_reg + VERTEX_BITS'(1);
                if (clr_addr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!q_status.empty) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        CMD_LOAD: begin
                            perm_we = 1'b1;
                        end
                        CMD_READ: begin
                            cnt_re     = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        CMD_EDGE: begin
                            perm_re     = 1'b1;
                            tgt_id_next = q_head.arg_b;
                            state_next  = S_E_PT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_COUNT;
                    out_src_next   = '0;
                    out_tgt_next   = '0;
                    out_cnt_next   = cnt_rdata;
                    state_next     = S_IDLE;
                end
            end
            // source mapping arrives, look up the target
            S_E_PT: begin
                src_map_next = perm_rdata;
                perm_re      = 1'b1;
                perm_raddr   = tgt_id_reg;
                state_next   = S_E_CS;
            end
            // target mapping arrives, read the source count
            S_E_CS: begin
                tgt_map_next = perm_rdata;
                cnt_re       = 1'b1;
                cnt_raddr    = src_map_reg;
                state_next   = S_E_WS;
            end
            S_E_WS: begin
                cnt_we     = 1'b1;
                cnt_waddr  = src_map_reg;
                state_next = S_E_CT;
            end
            // read after the source write, so a self loop counts twice
            S_E_CT: begin
                cnt_re     = 1'b1;
                cnt_raddr  = tgt_map_reg;
                state_next = S_E_WT;
            end
            S_E_WT: begin
                if (out_free) begin
                    cnt_we         = 1'b1;
                    cnt_waddr      = tgt_map_reg;
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_EDGE;
                    out_src_next   = src_map_reg;
                    out_tgt_next   = tgt_map_reg;
                    out_cnt_next   = '0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        tgt_id_reg   <= tgt_id_next;
        src_map_reg  <= src_map_next;
        tgt_map_reg  <= tgt_map_next;
        out_kind_reg <= out_kind_next;
        out_src_reg  <= out_src_next;
        out_tgt_reg  <= out_tgt_next;
        out_cnt_reg  <= out_cnt_next;
    end

    `ASSERT_IMPLIES(a_no_pop_in_clear, aclk, aresetn, state_reg == S_CLEAR, !q_pop)
    `ASSERT_IMPLIES(a_cnt_port_split, aclk, aresetn, cnt_we && cnt_re, cnt_waddr != cnt_raddr)
    `ASSERT_NEXT(a_edge_result, aclk, aresetn, state_reg == S_E_WT && out_free, m_valid && m_result_kind == RES_EDGE)

endmodule

`default_nettype wire

// File: rtl/core/recursive_matrix_edge_generator_core.sv
`default_nettype none

// R-MAT edge generator with a per-vertex degree histogram. Each draw request
// carries one random fraction that picks a quadrant and appends one bit to the
// source and target ids; after scale_bits draws the edge is mapped through the
// permutation table, both degree counts are bumped (saturating) and the edge is
// returned. Load requests fill the permutation table, read requests return one
// count; an edge may only map through entries that were loaded. Draws, loads,
// reads and ignored codes are accepted one per cycle by the front while the
// queue has room and the counts are not being cleared; edges, loads and reads
// are queued four deep for the back. The back runs one command at a time; an
// edge looks up both mappings and makes two read-modify-write passes through
// the count memory (one read and one write port), and reads and edges wait
// for a free result register. After reset the back clears all 2^VERTEX_BITS
// (65536) count entries with s_ready low; configuration writes are accepted
// at any time but are meant to be made only while the block is idle.
module recursive_matrix_edge_generator_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rmeg_pkg::OP_W-1:0]           s_operation,
    input  wire logic [rmeg_pkg::FRACTION_BITS-1:0]  s_draw_fraction,
    input  wire logic [rmeg_pkg::VERTEX_BITS-1:0]    s_vertex_index,
    input  wire logic [rmeg_pkg::VERTEX_BITS-1:0]    s_mapped_id,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_result_kind,
    output logic [rmeg_pkg::VERTEX_BITS-1:0]         m_source_vertex,
    output logic [rmeg_pkg::VERTEX_BITS-1:0]         m_target_vertex,
    output logic [rmeg_pkg::COUNT_BITS-1:0]          m_vertex_count,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rmeg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmeg_pkg::FRACTION_BITS-1:0]  cfg_wdata
);

    import rmeg_pkg::*;

    push_t         q_push;
    cmd_t          q_head;
    queue_status_t q_status;
    logic          q_pop;
    logic          back_clearing;

    rmeg_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_draw_fraction (s_draw_fraction),
        .s_vertex_index  (s_vertex_index),
        .s_mapped_id     (s_mapped_id),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .q_status        (q_status),
        .back_clearing   (back_clearing),
        .q_push          (q_push)
    );

    rmeg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .q_status (q_status)
    );

    rmeg_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_head          (q_head),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .back_clearing   (back_clearing),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_source_vertex (m_source_vertex),
        .m_target_vertex (m_target_vertex),
        .m_vertex_count  (m_vertex_count)
    );

endmodule

`default_nettype wire

// File: bench/tb_recursive_matrix_edge_generator_core.sv
`default_nettype none

module tb_recursive_matrix_edge_generator_core;
    import rmeg_pkg::*;

    typedef logic [VERTEX_BITS-1:0]   vertex_t;
    typedef logic [FRACTION_BITS-1:0] frac_t;
    typedef logic [COUNT_BITS-1:0]    count_t;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    // Register values after reset: 0.57, 0.76 and 0.95 of 2^24, truncated
    localparam logic [SCALE_W-1:0] RESET_SCALE  = 5'd16;
    localparam frac_t              RESET_TH_A   = 24'd9563013;
    localparam frac_t              RESET_TH_AB  = 24'd12750684;
    localparam frac_t              RESET_TH_ABC = 24'd15938355;

    // Wait after the last owed result, for the queue of four and the back end to drain
    localparam int DRAIN_CYCLES = 48;
    // Count clearing after reset alone covers 65536 count entries
    localparam int STALL_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASE_COUNT  = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic    kind;
        vertex_t src;
        vertex_t tgt;
        count_t  cnt;
    } edge_result_t;

    // Edge and degree predictor plus the queue of results still owed
    class edge_scoreboard;
        vertex_t            perm_map [vertex_t];
        count_t             degree [vertex_t];
        vertex_t            part_src;
        vertex_t            part_tgt;
        logic [SCALE_W-1:0] draws;
        logic [SCALE_W-1:0] scale_reg;
        frac_t              th_a;
        frac_t              th_ab;
        frac_t              th_abc;
        vertex_t            last_src;
        vertex_t            last_tgt;
        edge_result_t       owed_q[$];
        int                 errors;

        function new();
            part_src  = '0;
            part_tgt  = '0;
            draws     = '0;
            scale_reg = RESET_SCALE;
            th_a      = RESET_TH_A;
            th_ab     = RESET_TH_AB;
            th_abc    = RESET_TH_ABC;
            last_src  = '0;
            last_tgt  = '0;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, frac_t data);
            case (idx)
                CFG_SCALE: scale_reg = data[SCALE_W-1:0];
                CFG_TH_A:  th_a = data;
                CFG_TH_AB: th_ab = data;
                default:   th_abc = data;
            endcase
        endfunction

        function bit is_loaded(vertex_t idx);
            return perm_map.exists(idx);
        endfunction

        function vertex_t lookup(vertex_t idx);
            return perm_map.exists(idx) ? perm_map[idx] : '0;
        endfunction

        // Partial ids after this draw; true when the draw closes the edge
        function bit next_edge(frac_t frac, output vertex_t src_idx,
                               output vertex_t tgt_idx);
            logic               ub;
            logic               vb;
            logic [SCALE_W-1:0] taken;
            int                 eff;
            eff = scale_reg;
            if (eff < 1) eff = 1;
            if (eff > VERTEX_BITS) eff = VERTEX_BITS;
            ub = 1'b0;
            vb = 1'b0;
            // strict compares in fixed order, whatever the threshold order
            if (frac < th_a) begin
                ub = 1'b0;
            end else if (frac < th_ab) begin
                vb = 1'b1;
            end else if (frac < th_abc) begin
                ub = 1'b1;
            end else begin
                ub = 1'b1;
                vb = 1'b1;
            end
            src_idx = {part_src[VERTEX_BITS-2:0], ub};
            tgt_idx = {part_tgt[VERTEX_BITS-2:0], vb};
            taken = draws + 1'b1;
            return int'(taken) >= eff;
        endfunction

        function void bump(vertex_t id);
            if (!degree.exists(id)) degree[id] = '0;
            if (degree[id] != '1) degree[id] = degree[id] + 1'b1;
        endfunction

        function void note_request(logic [OP_W-1:0] op, frac_t frac, vertex_t idx,
                                   vertex_t mid);
            edge_result_t r;
            vertex_t      ns;
            vertex_t      nt;
            case (op)
                OP_LOAD: perm_map[idx] = mid;
                OP_READ: begin
                    r.kind = RES_COUNT;
                    r.src  = '0;
                    r.tgt  = '0;
                    r.cnt  = degree.exists(idx) ? degree[idx] : '0;
                    owed_q.push_back(r);
                end
                OP_DRAW: begin
                    if (next_edge(frac, ns, nt)) begin
                        r.kind = RES_EDGE;
                        r.src  = lookup(ns);
                        r.tgt  = lookup(nt);
                        r.cnt  = '0;
                        // self loop bumps the same count twice
                        bump(r.src);
                        bump(r.tgt);
                        last_src = r.src;
                        last_tgt = r.tgt;
                        part_src = '0;
                        part_tgt = '0;
                        draws    = '0;
                        owed_q.push_back(r);
                    end else begin
                        part_src = ns;
                        part_tgt = nt;
                        draws    = draws + 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= REPORT_MAX)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        endfunction

        function void check_result(logic kind, vertex_t src, vertex_t tgt, count_t cnt);
            edge_result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("result with nothing outstanding: kind %0d src %h tgt %h cnt %h",
                             kind, src, tgt, cnt);
                return;
            end
            want = owed_q.pop_front();
            if (kind !== want.kind) flag("result_kind", want.kind, kind);
            if (src !== want.src) flag("source_vertex", want.src, src);
            if (tgt !== want.tgt) flag("target_vertex", want.tgt, tgt);
            if (cnt !== want.cnt) flag("vertex_count", want.cnt, cnt);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void check_drained();
            if (owed_q.size() != 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0d results never arrived", owed_q.size());
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation = OP_DRAW;
    frac_t                s_draw_fraction = '0;
    vertex_t              s_vertex_index = '0;
    vertex_t              s_mapped_id = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_result_kind;
    vertex_t              m_source_vertex;
    vertex_t              m_target_vertex;
    count_t               m_vertex_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE;
    frac_t                cfg_wdata = '0;

    edge_scoreboard sb = new();

    int burst_left = 0;
    int idle_cycles = 0;
    int rdy_left = 0;
    int rdy_mode = 0;

    recursive_matrix_edge_generator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_draw_fraction (s_draw_fraction),
        .s_vertex_index  (s_vertex_index),
        .s_mapped_id     (s_mapped_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_source_vertex (m_source_vertex),
        .m_target_vertex (m_target_vertex),
        .m_vertex_count  (m_vertex_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Result check on every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_kind, m_source_vertex, m_target_vertex, m_vertex_count);
    end

    // Receiver backpressure: always ready, random, one in four, or a long stall
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(16, 96);
        end
        rdy_left = rdy_left - 1;
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 2) != 0);
            2: m_ready <= (rdy_left % 4 == 0);
            default: m_ready <= (rdy_left < 3);
        endcase
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("recursive_matrix_edge_generator_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One request, with a random gap between bursts
    task automatic issue(input logic [OP_W-1:0] op, input frac_t frac, input vertex_t idx,
                         input vertex_t mid);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_draw_fraction <= frac;
        s_vertex_index  <= idx;
        s_mapped_id     <= mid;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(op, frac, idx, mid);
    endtask

    // Draw request; loads any unwritten table entry the closing draw would map through
    task automatic send_draw(input frac_t frac);
        vertex_t src_idx;
        vertex_t tgt_idx;
        vertex_t mid;
        if (sb.next_edge(frac, src_idx, tgt_idx)) begin
            if (!sb.is_loaded(src_idx)) begin
                if ($urandom_range(0, 3) == 0 && sb.is_loaded(tgt_idx))
                    mid = sb.lookup(tgt_idx);
                else if ($urandom_range(0, 1) == 0)
                    mid = vertex_t'($urandom_range(0, 7));
                else
                    mid = vertex_t'($urandom);
                issue(OP_LOAD, frac_t'($urandom), src_idx, mid);
            end
            if (!sb.is_loaded(tgt_idx)) begin
                if ($urandom_range(0, 3) == 0)
                    mid = sb.lookup(src_idx);
                else if ($urandom_range(0, 1) == 0)
                    mid = vertex_t'($urandom_range(0, 7));
                else
                    mid = vertex_t'($urandom);
                issue(OP_LOAD, frac_t'($urandom), tgt_idx, mid);
            end
        end
        issue(OP_DRAW, frac, vertex_t'($urandom), vertex_t'($urandom));
    endtask

    // Register write; leaves cfg_valid high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input frac_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input frac_t scale_data, input frac_t a, input frac_t ab,
                             input frac_t abc);
        write_reg(CFG_SCALE, scale_data);
        write_reg(CFG_TH_A, a);
        write_reg(CFG_TH_AB, ab);
        write_reg(CFG_TH_ABC, abc);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every owed result is back and queued loads have drained
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mixed traffic: mostly draws, some loads, reads and ignored codes
    task automatic random_phase(input int items);
        int      pick;
        frac_t   frac;
        vertex_t idx;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 2))
                            0: frac = sb.th_a;
                            1: frac = sb.th_ab;
                            default: frac = sb.th_abc;
                        endcase
                        if ($urandom_range(0, 1) == 0) frac = frac - 1'b1;
                    end
                    1: frac = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    default: frac = frac_t'($urandom);
                endcase
                send_draw(frac);
            end else if (pick < 75) begin
                idx = ($urandom_range(0, 1) == 0) ? vertex_t'($urandom_range(0, 15))
                                                  : vertex_t'($urandom);
                issue(OP_LOAD, frac_t'($urandom), idx, vertex_t'($urandom));
            end else if (pick < 95) begin
                case ($urandom_range(0, 4))
                    0, 1: idx = sb.last_src;
                    2: idx = sb.last_tgt;
                    3: idx = vertex_t'($urandom_range(0, 15));
                    default: idx = vertex_t'($urandom);
                endcase
                issue(OP_READ, frac_t'($urandom), idx, vertex_t'($urandom));
            end else begin
                issue(OP_IGNORED, frac_t'($urandom), vertex_t'($urandom),
                      vertex_t'($urandom));
            end
        end
    endtask

    initial begin
        logic [SCALE_W-1:0] scale_plan [PHASE_COUNT];
        frac_t              scale_data;
        frac_t              r1;
        frac_t              r2;
        frac_t              r3;

        scale_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd3, 5'd4, 5'd6};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes at the reset configuration
        issue(OP_LOAD, '0, '0, '1);
        issue(OP_LOAD, '1, '1, '0);
        issue(OP_READ, '1, '0, '1);
        issue(OP_READ, '0, '1, '0);
        issue(OP_IGNORED, '1, '1, '1);
        send_draw(RESET_TH_A - 1'b1);
        send_draw(RESET_TH_A);
        send_draw(RESET_TH_AB - 1'b1);
        send_draw(RESET_TH_AB);
        send_draw(RESET_TH_ABC - 1'b1);
        send_draw(RESET_TH_ABC);
        send_draw('0);
        send_draw('1);
        repeat (8) send_draw(frac_t'($urandom));
        issue(OP_READ, frac_t'($urandom), sb.last_src, vertex_t'($urandom));
        issue(OP_READ, frac_t'($urandom), sb.last_tgt, vertex_t'($urandom));
        // leave a partial edge behind for the scale change
        repeat (3) send_draw(frac_t'($urandom));
        settle();

        // Directed: scale zero acts as one, unordered thresholds, self loops
        configure('0, 24'h400000, 24'h200000, 24'hC00000);
        send_draw(frac_t'($urandom));
        issue(OP_LOAD, frac_t'($urandom), vertex_t'(1), '1);
        send_draw(24'h600000);
        send_draw(24'h300000);
        send_draw('1);
        issue(OP_READ, frac_t'($urandom), '1, vertex_t'($urandom));
        settle();

        // Random phases, each under its own configuration
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            scale_data = frac_t'($urandom);
            scale_data[SCALE_W-1:0] = scale_plan[ph];
            if (ph == 2) begin
                r1 = '0;
                r2 = '0;
                r3 = '0;
            end else if (ph == 3) begin
                r1 = '1;
                r2 = '1;
                r3 = '1;
            end else begin
                r1 = frac_t'($urandom);
                r2 = frac_t'($urandom);
                r3 = frac_t'($urandom);
                // usually ordered, sometimes left unordered
                if ($urandom_range(0, 3) != 0) begin
                    if (r1 > r2) {r1, r2} = {r2, r1};
                    if (r2 > r3) {r2, r3} = {r3, r2};
                    if (r1 > r2) {r1, r2} = {r2, r1};
                end
            end
            configure(scale_data, r1, r2, r3);
            random_phase(PHASE_ITEMS);
            settle();
        end

        sb.check_drained();
        if (sb.errors == 0)
            $display("recursive_matrix_edge_generator_core verification clean");
        else
            $display("recursive_matrix_edge_generator_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/rmeg_pkg.sv
rtl/core/rmeg_ram.sv
rtl/core/rmeg_front.sv
rtl/core/rmeg_queue.sv
rtl/core/rmeg_back.sv
rtl/core/recursive_matrix_edge_generator_core.sv
bench/tb_recursive_matrix_edge_generator_core.sv
